// File: sv/stack_register_vm_executor_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stack/register machine executor
// Shared property forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef STACK_REGISTER_VM_EXECUTOR_ASSERT_SVH
`define STACK_REGISTER_VM_EXECUTOR_ASSERT_SVH

// Same-cycle implication.
`define SRVM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("executor assertion failed");

// Next-cycle implication.
`define SRVM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("executor assertion failed");

`endif

// File: sv/srvm_pkg.sv
// ----------------------------------------------------------------------------
// srvm_pkg
// Opcodes, status codes, result kinds and controller states of the executor.
// ----------------------------------------------------------------------------
`default_nettype none

package srvm_pkg;

    // Opcodes.
    localparam logic [7:0] OP_HALT    = 8'd0;
    localparam logic [7:0] OP_DISPLAY = 8'd1;
    localparam logic [7:0] OP_PRINT   = 8'd2;
    localparam logic [7:0] OP_PUSH    = 8'd10;
    localparam logic [7:0] OP_POP     = 8'd11;
    localparam logic [7:0] OP_MOV     = 8'd12;
    localparam logic [7:0] OP_CALL    = 8'd20;
    localparam logic [7:0] OP_RET     = 8'd21;
    localparam logic [7:0] OP_JMP     = 8'd22;
    localparam logic [7:0] OP_JZ      = 8'd23;
    localparam logic [7:0] OP_JPOS    = 8'd24;
    localparam logic [7:0] OP_JNEG    = 8'd25;
    localparam logic [7:0] OP_ADD     = 8'd30;
    localparam logic [7:0] OP_SUB     = 8'd31;
    localparam logic [7:0] OP_MUL     = 8'd32;
    localparam logic [7:0] OP_DIV     = 8'd33;

    // Stop status codes.
    localparam logic [3:0] ST_RUN         = 4'd0;
    localparam logic [3:0] ST_HALTED      = 4'd1;
    localparam logic [3:0] ST_STACK_OVER  = 4'd2;
    localparam logic [3:0] ST_STACK_UNDER = 4'd3;
    localparam logic [3:0] ST_ARITH_OVER  = 4'd4;
    localparam logic [3:0] ST_ARITH_UNDER = 4'd5;
    localparam logic [3:0] ST_DIV_ZERO    = 4'd6;
    localparam logic [3:0] ST_BAD_OPCODE  = 4'd7;
    localparam logic [3:0] ST_IP_END      = 4'd8;

    // Result kinds.
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_REG    = 2'd1;
    localparam logic [1:0] KIND_STACK  = 2'd2;
    localparam logic [1:0] KIND_EMPTY  = 2'd3;

    // Most stack entries shown by one print.
    localparam int MAX_OUT = 64;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_IDX1,
        S_RDA,
        S_IDX2,
        S_RDB,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_STK,
        S_PRN,
        S_FIN
    } state_t;

endpackage

`default_nettype wire

// File: sv/stack_register_vm_executor.sv
// ----------------------------------------------------------------------------
// stack_register_vm_executor
// Executes one fetched stack/register machine instruction per request.
// ----------------------------------------------------------------------------
// One instruction is taken at a time. Halt, jmp, call and any request to a
// stopped block go straight to their result; ret, jz, jpos and jneg first
// read the top of the stack; display, push, pop and mov reduce one register
// index; add, sub and mul reduce two and read two registers. Every register
// index is reduced modulo the register count at four bits per cycle. Div
// needs two index reductions, two reads of the register file RAM through its
// one read port and the divider. A print of n entries gives one result per
// entry, with one stack RAM read per entry. An empty stack or a count of
// zero or less gives one result. Results leave through an output register,
// and a stalled output stalls the sequencer. The register file and the stack
// each live in one RAM. The register file reads as zero until an entry is
// written, so it needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_register_vm_executor #(
    parameter int STACK_DEPTH   = 64,
    parameter int NUM_REGISTERS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  command,
    input  wire logic [31:0] first_operand,
    input  wire logic [31:0] second_operand,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [1:0]  result_kind,
    output logic      [31:0] shown_value,
    output logic      [5:0]  stack_position,
    output logic      [15:0] next_ip,
    output logic      [3:0]  status,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int RW  = $clog2(NUM_REGISTERS);

    srvm_pkg::state_t state_reg, state_next;

    logic [7:0]     cmd_reg, cmd_next;
    logic [31:0]    op1_reg, op1_next;
    logic [31:0]    op2_reg, op2_next;
    logic [15:0]    ip_reg, ip_next;
    logic [3:0]     status_reg, status_next;
    logic [15:0]    plen_reg, plen_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [31:0]    a_reg, a_next;
    logic [31:0]    b_reg, b_next;
    logic [63:0]    prod_reg;
    logic [1:0]     fin_kind_reg, fin_kind_next;
    logic [31:0]    fin_val_reg, fin_val_next;
    logic [SAW-1:0] slot_reg, slot_next;
    logic [6:0]     remain_reg, remain_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  kind_out_reg, kind_out_next;
    logic [31:0] val_out_reg, val_out_next;
    logic [5:0]  pos_out_reg, pos_out_next;
    logic [15:0] ip_out_reg, ip_out_next;
    logic [3:0]  status_out_reg, status_out_next;
    logic        last_out_reg, last_out_next;

    logic [NUM_REGISTERS-1:0] rf_valid_reg, rf_valid_next;
    logic                     rf_vq_reg, rf_vq_next;

    // Memory ports.
    logic           rf_we, rf_re;
    logic [RW-1:0]  rf_waddr, rf_raddr;
    logic [31:0]    rf_wdata, rf_rdata, rf_val;
    logic           st_we, st_re;
    logic [SAW-1:0] st_waddr, st_raddr;
    logic [31:0]    st_wdata, st_rdata;

    // Helper units.
    logic          red_start, red_done;
    logic [31:0]   red_value;
    logic [RW-1:0] red_index;
    logic          div_start, div_done, div_neg;
    logic [31:0]   div_quot;

    // Decode helpers.
    logic           can_emit, sp_full, sp_empty;
    logic [SAW-1:0] sp_top;
    logic [31:0]    sp32, cap32, cnt32;
    logic [15:0]    ip_plus2, ip_plus3;
    logic           commit_en;
    logic [15:0]    commit_ip;
    logic           arith_go, arith_over, arith_under;
    logic [31:0]    arith_val;
    logic [32:0]    sum33;
    logic           mul_fit;
    logic           take;

    srvm_ram #(
        .WIDTH (32),
        .DEPTH (NUM_REGISTERS)
    ) u_rf_ram (
        .clk     (clk),
        .wr_en   (rf_we),
        .wr_addr (rf_waddr),
        .wr_data (rf_wdata),
        .rd_en   (rf_re),
        .rd_addr (rf_raddr),
        .rd_data (rf_rdata)
    );

    srvm_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (st_wdata),
        .rd_en   (st_re),
        .rd_addr (st_raddr),
        .rd_data (st_rdata)
    );

    srvm_index_reduce #(
        .NUM_REGISTERS (NUM_REGISTERS)
    ) u_index_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .start (red_start),
        .value (red_value),
        .done  (red_done),
        .index (red_index)
    );

    srvm_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (a_reg),
        .divisor  (b_reg),
        .done     (div_done),
        .quot     (div_quot),
        .neg      (div_neg)
    );

    // Shared decode terms.
    always_comb
    begin
        can_emit = !out_valid_reg || out_ready;
        sp_full  = (sp_reg == SPW'(STACK_DEPTH));
        sp_empty = (sp_reg == '0);
        sp_top   = SAW'(sp_reg - SPW'(1));
        ip_plus2 = ip_reg + 16'd2;
        ip_plus3 = ip_reg + 16'd3;
        rf_val   = rf_vq_reg ? rf_rdata : 32'd0;
        // Print count: min(n, sp, MAX_OUT) for a positive n.
        sp32  = 32'(sp_reg);
        cap32 = (sp32 > 32'(srvm_pkg::MAX_OUT)) ? 32'(srvm_pkg::MAX_OUT) : sp32;
        if (first_operand[31] || first_operand == 32'd0)
        begin
            cnt32 = 32'd0;
        end
        else
        begin
            cnt32 = (first_operand < cap32) ? first_operand : cap32;
        end
        // Checked arithmetic results.
        if (cmd_reg == srvm_pkg::OP_SUB)
        begin
            sum33 = {a_reg[31], a_reg} - {b_reg[31], b_reg};
        end
        else
        begin
            sum33 = {a_reg[31], a_reg} + {b_reg[31], b_reg};
        end
        mul_fit = (&prod_reg[63:31]) || (~|prod_reg[63:31]);
        take = 1'b0;
        case (cmd_reg)
            srvm_pkg::OP_JZ:   take = (st_rdata == 32'd0);
            srvm_pkg::OP_JPOS: take = !st_rdata[31] && (st_rdata != 32'd0);
            srvm_pkg::OP_JNEG: take = st_rdata[31];
            default:           take = 1'b0;
        endcase
    end

    // Sequencer: next state, memory requests and result formation.
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        op1_next        = op1_reg;
        op2_next        = op2_reg;
        ip_next         = ip_reg;
        status_next     = status_reg;
        plen_next       = plen_reg;
        sp_next         = sp_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        fin_kind_next   = fin_kind_reg;
        fin_val_next    = fin_val_reg;
        slot_next       = slot_reg;
        remain_next     = remain_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        kind_out_next   = kind_out_reg;
        val_out_next    = val_out_reg;
        pos_out_next    = pos_out_reg;
        ip_out_next     = ip_out_reg;
        status_out_next = status_out_reg;
        last_out_next   = last_out_reg;
        rf_valid_next   = rf_valid_reg;
        rf_vq_next      = rf_vq_reg;
        rf_we           = 1'b0;
        rf_waddr        = red_index;
        rf_wdata        = 32'd0;
        rf_re           = 1'b0;
        rf_raddr        = red_index;
        st_we           = 1'b0;
        st_waddr        = SAW'(sp_reg);
        st_wdata        = 32'd0;
        st_re           = 1'b0;
        st_raddr        = sp_top;
        red_start       = 1'b0;
        red_value       = first_operand;
        div_start       = 1'b0;
        commit_en       = 1'b0;
        commit_ip       = ip_reg;
        arith_go        = 1'b0;
        arith_over      = 1'b0;
        arith_under     = 1'b0;
        arith_val       = sum33[31:0];
        in_ready        = (state_reg == srvm_pkg::S_IDLE);
        cfg_ready       = 1'b1;

        if (cfg_valid)
        begin
            plen_next = cfg_data;
        end

        case (state_reg)
            srvm_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next      = command;
                    op1_next      = first_operand;
                    op2_next      = second_operand;
                    fin_kind_next = srvm_pkg::KIND_STATUS;
                    fin_val_next  = 32'd0;
                    state_next    = srvm_pkg::S_FIN;
                    if (status_reg != srvm_pkg::ST_RUN)
                    begin
                        status_next = status_reg;
                    end
                    else if (ip_reg >= plen_reg)
                    begin
                        status_next = srvm_pkg::ST_IP_END;
                    end
                    else
                    begin
                        case (command)
                            srvm_pkg::OP_HALT:
                            begin
                                status_next = srvm_pkg::ST_HALTED;
                            end
                            srvm_pkg::OP_DISPLAY, srvm_pkg::OP_MOV:
                            begin
                                red_start  = 1'b1;
                                state_next = srvm_pkg::S_IDX1;
                            end
                            srvm_pkg::OP_PUSH, srvm_pkg::OP_ADD, srvm_pkg::OP_SUB,
                            srvm_pkg::OP_MUL, srvm_pkg::OP_DIV:
                            begin
                                if (sp_full)
                                begin
                                    status_next = srvm_pkg::ST_STACK_OVER;
                                end
                                else
                                begin
                                    red_start  = 1'b1;
                                    state_next = srvm_pkg::S_IDX1;
                                end
                            end
                            srvm_pkg::OP_POP:
                            begin
                                if (sp_empty)
                                begin
                                    status_next = srvm_pkg::ST_STACK_UNDER;
                                end
                                else
                                begin
                                    st_re      = 1'b1;
                                    red_start  = 1'b1;
                                    state_next = srvm_pkg::S_IDX1;
                                end
                            end
                            srvm_pkg::OP_PRINT:
                            begin
                                commit_en = 1'b1;
                                commit_ip = ip_plus2;
                                if (sp_empty)
                                begin
                                    fin_kind_next = srvm_pkg::KIND_EMPTY;
                                end
                                else if (cnt32 != 32'd0)
                                begin
                                    st_re       = 1'b1;
                                    slot_next   = sp_top;
                                    remain_next = cnt32[6:0];
                                    state_next  = srvm_pkg::S_PRN;
                                end
                            end
                            srvm_pkg::OP_CALL:
                            begin
                                if (sp_full)
                                begin
                                    status_next = srvm_pkg::ST_STACK_OVER;
                                end
                                else
                                begin
                                    st_we     = 1'b1;
                                    st_wdata  = 32'(ip_plus2);
                                    sp_next   = sp_reg + SPW'(1);
                                    commit_en = 1'b1;
                                    commit_ip = first_operand[15:0];
                                end
                            end
                            srvm_pkg::OP_RET, srvm_pkg::OP_JZ, srvm_pkg::OP_JPOS,
                            srvm_pkg::OP_JNEG:
                            begin
                                if (sp_empty)
                                begin
                                    status_next = srvm_pkg::ST_STACK_UNDER;
                                end
                                else
                                begin
                                    st_re      = 1'b1;
                                    state_next = srvm_pkg::S_STK;
                                end
                            end
                            srvm_pkg::OP_JMP:
                            begin
                                commit_en = 1'b1;
                                commit_ip = first_operand[15:0];
                            end
                            default:
                            begin
                                status_next = srvm_pkg::ST_BAD_OPCODE;
                            end
                        endcase
                    end
                end
            end

            // First register index is ready.
            srvm_pkg::S_IDX1:
            begin
                if (red_done)
                begin
                    case (cmd_reg)
                        srvm_pkg::OP_MOV:
                        begin
                            rf_we                    = 1'b1;
                            rf_wdata                 = op2_reg;
                            rf_valid_next[red_index] = 1'b1;
                            commit_en                = 1'b1;
                            commit_ip                = ip_plus3;
                            state_next               = srvm_pkg::S_FIN;
                        end
                        srvm_pkg::OP_POP:
                        begin
                            rf_we                    = 1'b1;
                            rf_wdata                 = st_rdata;
                            rf_valid_next[red_index] = 1'b1;
                            sp_next                  = sp_reg - SPW'(1);
                            commit_en                = 1'b1;
                            commit_ip                = ip_plus2;
                            state_next               = srvm_pkg::S_FIN;
                        end
                        default:
                        begin
                            rf_re      = 1'b1;
                            rf_vq_next = rf_valid_reg[red_index];
                            state_next = srvm_pkg::S_RDA;
                        end
                    endcase
                end
            end

            // First register value is ready.
            srvm_pkg::S_RDA:
            begin
                case (cmd_reg)
                    srvm_pkg::OP_DISPLAY:
                    begin
                        fin_kind_next = srvm_pkg::KIND_REG;
                        fin_val_next  = rf_val;
                        commit_en     = 1'b1;
                        commit_ip     = ip_plus2;
                        state_next    = srvm_pkg::S_FIN;
                    end
                    srvm_pkg::OP_PUSH:
                    begin
                        st_we      = 1'b1;
                        st_wdata   = rf_val;
                        sp_next    = sp_reg + SPW'(1);
                        commit_en  = 1'b1;
                        commit_ip  = ip_plus2;
                        state_next = srvm_pkg::S_FIN;
                    end
                    default:
                    begin
                        a_next     = rf_val;
                        red_start  = 1'b1;
                        red_value  = op2_reg;
                        state_next = srvm_pkg::S_IDX2;
                    end
                endcase
            end

            srvm_pkg::S_IDX2:
            begin
                if (red_done)
                begin
                    rf_re      = 1'b1;
                    rf_vq_next = rf_valid_reg[red_index];
                    state_next = srvm_pkg::S_RDB;
                end
            end

            srvm_pkg::S_RDB:
            begin
                b_next     = rf_val;
                state_next = srvm_pkg::S_EXEC;
            end

            // Operands are in a_reg and b_reg.
            srvm_pkg::S_EXEC:
            begin
                case (cmd_reg)
                    srvm_pkg::OP_MUL:
                    begin
                        state_next = srvm_pkg::S_MUL;
                    end
                    srvm_pkg::OP_DIV:
                    begin
                        if (b_reg == 32'd0)
                        begin
                            status_next = srvm_pkg::ST_DIV_ZERO;
                            state_next  = srvm_pkg::S_FIN;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = srvm_pkg::S_DIV;
                        end
                    end
                    default:
                    begin
                        arith_go    = 1'b1;
                        arith_over  = !sum33[32] && sum33[31];
                        arith_under = sum33[32] && !sum33[31];
                        arith_val   = sum33[31:0];
                    end
                endcase
            end

            srvm_pkg::S_MUL:
            begin
                arith_go    = 1'b1;
                arith_over  = !prod_reg[63] && !mul_fit;
                arith_under = prod_reg[63] && !mul_fit;
                arith_val   = prod_reg[31:0];
            end

            srvm_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    arith_go   = 1'b1;
                    arith_over = !div_neg && div_quot[31];
                    arith_val  = div_neg ? (32'd0 - div_quot) : div_quot;
                end
            end

            // Top of stack is ready for ret and the conditional jumps.
            srvm_pkg::S_STK:
            begin
                sp_next    = sp_reg - SPW'(1);
                commit_en  = 1'b1;
                state_next = srvm_pkg::S_FIN;
                if (cmd_reg == srvm_pkg::OP_RET)
                begin
                    commit_ip = st_rdata[15:0];
                end
                else
                begin
                    commit_ip = take ? op1_reg[15:0] : ip_plus2;
                end
            end

            // One stack entry per result, from the top down.
            srvm_pkg::S_PRN:
            begin
                if (can_emit)
                begin
                    out_valid_next  = 1'b1;
                    kind_out_next   = srvm_pkg::KIND_STACK;
                    val_out_next    = st_rdata;
                    pos_out_next    = 6'(slot_reg);
                    ip_out_next     = ip_reg;
                    status_out_next = status_reg;
                    last_out_next   = (remain_reg == 7'd1);
                    if (remain_reg == 7'd1)
                    begin
                        state_next = srvm_pkg::S_IDLE;
                    end
                    else
                    begin
                        slot_next   = slot_reg - SAW'(1);
                        remain_next = remain_reg - 7'd1;
                        st_re       = 1'b1;
                        st_raddr    = slot_reg - SAW'(1);
                    end
                end
            end

            // Final result of the instruction.
            srvm_pkg::S_FIN:
            begin
                if (can_emit)
                begin
                    out_valid_next  = 1'b1;
                    kind_out_next   = fin_kind_reg;
                    val_out_next    = fin_val_reg;
                    pos_out_next    = 6'd0;
                    ip_out_next     = ip_reg;
                    status_out_next = status_reg;
                    last_out_next   = 1'b1;
                    state_next      = srvm_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = srvm_pkg::S_IDLE;
            end
        endcase

        // Checked arithmetic result is pushed or stops the block.
        if (arith_go)
        begin
            state_next = srvm_pkg::S_FIN;
            if (arith_over)
            begin
                status_next = srvm_pkg::ST_ARITH_OVER;
            end
            else if (arith_under)
            begin
                status_next = srvm_pkg::ST_ARITH_UNDER;
            end
            else
            begin
                st_we     = 1'b1;
                st_wdata  = arith_val;
                sp_next   = sp_reg + SPW'(1);
                commit_en = 1'b1;
                commit_ip = ip_plus3;
            end
        end

        // A successful instruction moves ip and may run off the program.
        if (commit_en)
        begin
            ip_next = commit_ip;
            if (commit_ip >= plen_reg)
            begin
                status_next = srvm_pkg::ST_IP_END;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srvm_pkg::S_IDLE;
            ip_reg        <= 16'd0;
            status_reg    <= srvm_pkg::ST_RUN;
            plen_reg      <= 16'hFFFF;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
            rf_valid_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ip_reg        <= ip_next;
            status_reg    <= status_next;
            plen_reg      <= plen_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
            rf_valid_reg  <= rf_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        op1_reg        <= op1_next;
        op2_reg        <= op2_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        fin_kind_reg   <= fin_kind_next;
        fin_val_reg    <= fin_val_next;
        slot_reg       <= slot_next;
        remain_reg     <= remain_next;
        kind_out_reg   <= kind_out_next;
        val_out_reg    <= val_out_next;
        pos_out_reg    <= pos_out_next;
        ip_out_reg     <= ip_out_next;
        status_out_reg <= status_out_next;
        last_out_reg   <= last_out_next;
        rf_vq_reg      <= rf_vq_next;
        if (state_reg == srvm_pkg::S_EXEC)
        begin
            prod_reg <= 64'($signed(a_reg) * $signed(b_reg));
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = kind_out_reg;
    assign shown_value    = val_out_reg;
    assign stack_position = pos_out_reg;
    assign next_ip        = ip_out_reg;
    assign status         = status_out_reg;
    assign last           = last_out_reg;

    // Checks on the sequencer.
    `include "stack_register_vm_executor_assert.svh"

    `SRVM_ASSERT_NOW(a_sp_bound, 1'b1, sp_reg <= SPW'(STACK_DEPTH))
    `SRVM_ASSERT_NEXT(a_stop_sticky, status_reg != srvm_pkg::ST_RUN, status_reg == $past(status_reg))
    `SRVM_ASSERT_NOW(a_div_owner, div_done, state_reg == srvm_pkg::S_DIV)

endmodule

`default_nettype wire

// File: sv/srvm_ram.sv
// ----------------------------------------------------------------------------
// srvm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module srvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/srvm_index_reduce.sv
// ----------------------------------------------------------------------------
// srvm_index_reduce
// Reduces a 32-bit unsigned operand modulo the register count, four bits
// per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srvm_index_reduce #(
    parameter int NUM_REGISTERS = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [31:0]                      value,
    output logic                                  done,
    output logic      [$clog2(NUM_REGISTERS)-1:0] index
);

    localparam int RW     = $clog2(NUM_REGISTERS);
    localparam int STEPS  = 4;
    localparam int PASSES = 32 / STEPS;
    localparam int CW     = $clog2(PASSES);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0]   sh_reg, sh_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-1:0] rem_step;
    logic [RW:0]   tmp;

    // Four remainder steps on the top bits of the shifter.
    always_comb
    begin
        rem_step = rem_reg;
        tmp      = '0;
        for (int j = 0; j < STEPS; j++)
        begin
            tmp = {rem_step, sh_reg[31-j]};
            if (tmp >= (RW+1)'(NUM_REGISTERS))
            begin
                tmp = tmp - (RW+1)'(NUM_REGISTERS);
            end
            rem_step = tmp[RW-1:0];
        end
    end

    // Sequencing.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            sh_next   = value;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            sh_next  = sh_reg << STEPS;
            rem_next = rem_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(PASSES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    assign done  = done_reg;
    assign index = rem_reg;

endmodule

`default_nettype wire

// File: sv/srvm_divider.sv
// ----------------------------------------------------------------------------
// srvm_divider
// Signed 32-bit restoring divider, one quotient bit per cycle. Gives the
// quotient magnitude and its sign; truncates toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module srvm_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic      [31:0] quot,
    output logic             neg
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic [32:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        trial     = {r_reg[31:0], q_reg[31]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend[31] ? (32'd0 - dividend) : dividend;
            d_next    = divisor[31] ? (32'd0 - divisor) : divisor;
            r_next    = '0;
            neg_next  = dividend[31] ^ divisor[31];
        end
        else if (busy_reg)
        begin
            // Shift in the next dividend bit and try to subtract.
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign neg  = neg_reg;

endmodule

`default_nettype wire

// File: verif/stack_register_vm_executor_checker.sv
// ----------------------------------------------------------------------------
// Stack/register machine executor checker
// Watches the instruction, result and length-write channels of the executor,
// keeps its own copy of the machine state, predicts the results of every
// accepted request and compares each accepted result with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stack_register_vm_executor_checker
    import srvm_pkg::*;
#(
    parameter int STACK_DEPTH   = 64,
    parameter int NUM_REGISTERS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  command,
    input  logic [31:0] first_operand,
    input  logic [31:0] second_operand,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  result_kind,
    input  logic [31:0] shown_value,
    input  logic [5:0]  stack_position,
    input  logic [15:0] next_ip,
    input  logic [3:0]  status,
    input  logic        last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output logic [6:0]  sp_view,
    output logic [15:0] ip_view,
    output logic [3:0]  status_view,
    output logic [31:0] reg_view [NUM_REGISTERS],
    output logic [31:0] stack_view [STACK_DEPTH]
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [5:0]  pos;
        logic [15:0] ip;
        logic [3:0]  st;
        logic        lst;
    } vm_result_t;

    vm_result_t  expected_q [$];
    logic [15:0] prog_len;

    // Run one instruction on the shadow machine and queue what it shows.
    task automatic execute_instruction(input logic [7:0] cmd, input logic [31:0] op1,
                                       input logic [31:0] op2);
        vm_result_t  shown [$];
        vm_result_t  item;
        logic [15:0] nip;
        logic [3:0]  err;
        logic [31:0] ia;
        logic [31:0] ib;
        logic [6:0]  slot;
        longint      a;
        longint      b;
        longint      res;
        longint      want;
        longint      top_val;
        int          cnt;
        logic        take;
        ia   = op1 % 32'(NUM_REGISTERS);
        ib   = op2 % 32'(NUM_REGISTERS);
        nip  = ip_view;
        err  = ST_RUN;
        item = '0;
        if (status_view == ST_RUN && ip_view >= prog_len)
            status_view = ST_IP_END;
        if (status_view == ST_RUN)
        begin
            case (cmd)
                OP_HALT: err = ST_HALTED;
                OP_DISPLAY:
                begin
                    item.kind  = KIND_REG;
                    item.value = reg_view[ia];
                    shown.push_back(item);
                    nip = ip_view + 16'd2;
                end
                OP_PRINT:
                begin
                    if (sp_view == 0)
                    begin
                        item.kind = KIND_EMPTY;
                        shown.push_back(item);
                    end
                    else
                    begin
                        want = longint'($signed(op1));
                        cnt  = 0;
                        if (want > 0)
                            cnt = (want < longint'(sp_view)) ? int'(want) : int'(sp_view);
                        if (cnt > MAX_OUT)
                            cnt = MAX_OUT;
                        for (int i = 0; i < cnt; i++)
                        begin
                            slot       = sp_view - 7'd1 - 7'(i);
                            item.kind  = KIND_STACK;
                            item.value = stack_view[slot];
                            item.pos   = slot[5:0];
                            shown.push_back(item);
                        end
                    end
                    nip = ip_view + 16'd2;
                end
                OP_PUSH:
                begin
                    if (sp_view >= STACK_DEPTH)
                        err = ST_STACK_OVER;
                    else
                    begin
                        stack_view[sp_view] = reg_view[ia];
                        sp_view = sp_view + 7'd1;
                        nip = ip_view + 16'd2;
                    end
                end
                OP_POP:
                begin
                    if (sp_view == 0)
                        err = ST_STACK_UNDER;
                    else
                    begin
                        sp_view = sp_view - 7'd1;
                        reg_view[ia] = stack_view[sp_view];
                        nip = ip_view + 16'd2;
                    end
                end
                OP_MOV:
                begin
                    reg_view[ia] = op2;
                    nip = ip_view + 16'd3;
                end
                OP_CALL:
                begin
                    if (sp_view >= STACK_DEPTH)
                        err = ST_STACK_OVER;
                    else
                    begin
                        stack_view[sp_view] = {16'd0, ip_view + 16'd2};
                        sp_view = sp_view + 7'd1;
                        nip = op1[15:0];
                    end
                end
                OP_RET:
                begin
                    if (sp_view == 0)
                        err = ST_STACK_UNDER;
                    else
                    begin
                        sp_view = sp_view - 7'd1;
                        nip = stack_view[sp_view][15:0];
                    end
                end
                OP_JMP: nip = op1[15:0];
                OP_JZ, OP_JPOS, OP_JNEG:
                begin
                    if (sp_view == 0)
                        err = ST_STACK_UNDER;
                    else
                    begin
                        top_val = longint'($signed(stack_view[sp_view - 7'd1]));
                        if (cmd == OP_JZ)
                            take = (top_val == 0);
                        else if (cmd == OP_JPOS)
                            take = (top_val > 0);
                        else
                            take = (top_val < 0);
                        nip = take ? op1[15:0] : ip_view + 16'd2;
                        sp_view = sp_view - 7'd1;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                begin
                    a = longint'($signed(reg_view[ia]));
                    b = longint'($signed(reg_view[ib]));
                    if (sp_view >= STACK_DEPTH)
                        err = ST_STACK_OVER;
                    else if (cmd == OP_DIV && b == 0)
                        err = ST_DIV_ZERO;
                    else
                    begin
                        if (cmd == OP_ADD)
                            res = a + b;
                        else if (cmd == OP_SUB)
                            res = a - b;
                        else if (cmd == OP_MUL)
                            res = a * b;
                        else
                            res = a / b;
                        if (res > 64'sd2147483647)
                            err = ST_ARITH_OVER;
                        else if (res < -64'sd2147483648)
                            err = ST_ARITH_UNDER;
                        else
                        begin
                            stack_view[sp_view] = res[31:0];
                            sp_view = sp_view + 7'd1;
                            nip = ip_view + 16'd3;
                        end
                    end
                end
                default: err = ST_BAD_OPCODE;
            endcase
            if (err != ST_RUN)
                status_view = err;
            else
            begin
                ip_view = nip;
                if (ip_view >= prog_len)
                    status_view = ST_IP_END;
            end
        end
        if (shown.size() == 0)
        begin
            item      = '0;
            item.kind = KIND_STATUS;
            shown.push_back(item);
        end
        foreach (shown[k])
        begin
            shown[k].ip  = ip_view;
            shown[k].st  = status_view;
            shown[k].lst = (k == shown.size() - 1);
            expected_q.push_back(shown[k]);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (expv !== actv)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, expv, actv);
            fail_count++;
        end
    endtask

    // Shadow machine update and result comparison.
    always @(posedge clk or negedge rst_n)
    begin
        vm_result_t got;
        if (!rst_n)
        begin
            prog_len    = 16'hFFFF;
            sp_view     = '0;
            ip_view     = '0;
            status_view = ST_RUN;
            for (int i = 0; i < NUM_REGISTERS; i++)
                reg_view[i] = '0;
            for (int i = 0; i < STACK_DEPTH; i++)
                stack_view[i] = '0;
            expected_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                prog_len = cfg_data;
            if (in_valid && in_ready)
                execute_instruction(command, first_operand, second_operand);
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result: kind %0d value 0x%0h", result_kind, shown_value);
                    fail_count++;
                end
                else
                begin
                    got = expected_q.pop_front();
                    check_field("result_kind", 32'(got.kind), 32'(result_kind));
                    check_field("shown_value", got.value, shown_value);
                    check_field("stack_position", 32'(got.pos), 32'(stack_position));
                    check_field("next_ip", 32'(got.ip), 32'(next_ip));
                    check_field("status", 32'(got.st), 32'(status));
                    check_field("last", 32'(got.lst), 32'(last));
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

// File: verif/stack_register_vm_executor_tb.sv
// ----------------------------------------------------------------------------
// Stack/register machine executor testbench
// Drives directed and mostly well-formed random instruction streams with
// bursty requests, a stalling result side and program length changes, ends
// with one stop condition and ignored traffic, and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stack_register_vm_executor_tb;
    import srvm_pkg::*;

    localparam int NREG       = 32;
    localparam int NSTACK     = 64;
    localparam int IDLE_LIMIT = 4000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  command = '0;
    logic [31:0] first_operand = '0;
    logic [31:0] second_operand = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  result_kind;
    logic [31:0] shown_value;
    logic [5:0]  stack_position;
    logic [15:0] next_ip;
    logic [3:0]  status;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    int          fail_count;
    int          pending;
    logic [6:0]  sp_view;
    logic [15:0] ip_view;
    logic [3:0]  status_view;
    logic [31:0] reg_view [NREG];
    logic [31:0] stack_view [NSTACK];

    logic [15:0] plen_cur = 16'hFFFF;
    int          sent_count = 0;
    int          push_bias = 10;
    int          idle_cycles = 0;
    int          rx_mode = 0;
    int          rx_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    stack_register_vm_executor #(.STACK_DEPTH(NSTACK), .NUM_REGISTERS(NREG)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .first_operand(first_operand), .second_operand(second_operand),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_kind(result_kind), .shown_value(shown_value),
        .stack_position(stack_position), .next_ip(next_ip), .status(status), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    stack_register_vm_executor_checker #(.STACK_DEPTH(NSTACK), .NUM_REGISTERS(NREG)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .first_operand(first_operand), .second_operand(second_operand),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_kind(result_kind), .shown_value(shown_value),
        .stack_position(stack_position), .next_ip(next_ip), .status(status), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending),
        .sp_view(sp_view), .ip_view(ip_view), .status_view(status_view),
        .reg_view(reg_view), .stack_view(stack_view)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result side: random stall patterns, plus one long hold-off.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!hold_done && sent_count >= 300)
        begin
            hold_done = 1'b1;
            hold_left = 400;
            out_ready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(16, 96);
            end
            rx_left--;
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Watchdog on cycles without any accepted request, result or length write.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** stack_register_vm_executor: FAILED **");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send(input logic [7:0] c, input logic [31:0] a, input logic [31:0] b);
        in_valid       <= 1'b1;
        command        <= c;
        first_operand  <= a;
        second_operand <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        in_valid   <= 1'b0;
        sent_count <= sent_count + 1;
    endtask

    task automatic issue(input logic [7:0] c, input logic [31:0] a, input logic [31:0] b);
        @(negedge clk);
        @(posedge clk);
        send(c, a, b);
    endtask

    // Sample the outstanding count away from the clock edge.
    task automatic wait_drained();
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // Park the ip low, let the block settle, then write the program length.
    task automatic write_length(input logic [15:0] v);
        issue(OP_JMP, {16'($urandom), 16'd2}, $urandom);
        wait_drained();
        repeat (60) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        plen_cur = v;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0;
            4: return 32'($urandom_range(0, 200)) - 32'd100;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_count();
        case ($urandom_range(0, 5))
            0: return 32'($urandom_range(0, 70));
            1: return 32'd64;
            2: return $urandom;
            3: return -32'($urandom_range(0, 5));
            default: return 32'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic bit arith_safe(input logic [7:0] c, input logic [31:0] x,
                                      input logic [31:0] y);
        longint a;
        longint b;
        longint r;
        a = longint'($signed(x));
        b = longint'($signed(y));
        if (c == OP_DIV && b == 0)
            return 1'b0;
        if (c == OP_ADD)
            r = a + b;
        else if (c == OP_SUB)
            r = a - b;
        else if (c == OP_MUL)
            r = a * b;
        else
            r = a / b;
        return (r <= 64'sd2147483647) && (r >= -64'sd2147483648);
    endfunction

    // Choose an instruction that keeps the machine running, from the shadow state.
    task automatic pick_instruction(output logic [7:0] c, output logic [31:0] a,
                                    output logic [31:0] b);
        int          lim;
        int          sel;
        bit          ok;
        logic [15:0] tgt;
        lim = int'(plen_cur) - 4;
        c   = OP_JMP;
        a   = {16'($urandom), 16'($urandom_range(0, lim))};
        b   = $urandom;
        if (int'(ip_view) > lim)
            return;
        for (int tries = 0; tries < 30; tries++)
        begin
            sel = $urandom_range(0, 99);
            a   = $urandom;
            b   = $urandom;
            tgt = 16'($urandom_range(0, lim));
            if (sel < push_bias)
                c = OP_PUSH;
            else
            begin
                case (sel % 15)
                    0: c = OP_DISPLAY;
                    1: c = OP_PRINT;
                    2: c = OP_POP;
                    3: c = OP_MOV;
                    4: c = OP_CALL;
                    5: c = OP_RET;
                    6: c = OP_JMP;
                    7: c = OP_JZ;
                    8: c = OP_JPOS;
                    9: c = OP_JNEG;
                    10: c = OP_ADD;
                    11: c = OP_SUB;
                    12: c = OP_MUL;
                    13: c = OP_DIV;
                    default: c = OP_MOV;
                endcase
            end
            case (c)
                OP_PRINT: a = pick_count();
                OP_MOV: b = pick_value();
                OP_CALL, OP_JMP, OP_JZ, OP_JPOS, OP_JNEG: a = {a[31:16], tgt};
                default: ;
            endcase
            case (c)
                OP_PUSH, OP_CALL: ok = (sp_view < NSTACK);
                OP_POP, OP_JZ, OP_JPOS, OP_JNEG: ok = (sp_view > 0);
                OP_RET: ok = (sp_view > 0) && (int'(stack_view[sp_view - 7'd1][15:0]) <= lim);
                OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                    ok = (sp_view < NSTACK) && arith_safe(c, reg_view[a % NREG], reg_view[b % NREG]);
                default: ok = 1'b1;
            endcase
            if (ok)
                return;
        end
        c = OP_JMP;
        a = {16'($urandom), tgt};
    endtask

    // Bursts of running instructions separated by random gaps.
    task automatic run_random(input int count, input bit drain_midway);
        logic [7:0]  c;
        logic [31:0] a;
        logic [31:0] b;
        int          done;
        int          burst;
        done = 0;
        while (done < count)
        begin
            burst     = $urandom_range(1, 12);
            push_bias = ($urandom_range(0, 3) == 0) ? 70 : $urandom_range(0, 25);
            for (int j = 0; j < burst && done < count; j++)
            begin
                @(negedge clk);
                pick_instruction(c, a, b);
                @(posedge clk);
                send(c, a, b);
                done++;
                if (drain_midway && done == count / 2)
                    wait_drained();
            end
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic fill_stack();
        forever
        begin
            @(negedge clk);
            if (sp_view >= NSTACK)
                break;
            @(posedge clk);
            send(OP_PUSH, $urandom, $urandom);
        end
    endtask

    task automatic make_room();
        @(negedge clk);
        if (sp_view >= NSTACK)
            issue(OP_POP, 32'd5, $urandom);
    endtask

    // Bring the machine to one stop condition chosen at random.
    task automatic provoke_stop();
        logic [7:0] c;
        issue(OP_JMP, {16'($urandom), 16'd0}, $urandom);
        case ($urandom_range(0, 9))
            0: issue(OP_HALT, $urandom, $urandom);
            1:
            begin
                fill_stack();
                issue(OP_PUSH, $urandom, $urandom);
            end
            2:
            begin
                fill_stack();
                issue(OP_CALL, 32'd10, $urandom);
            end
            3:
            begin
                forever
                begin
                    @(negedge clk);
                    if (sp_view == 0)
                        break;
                    @(posedge clk);
                    send(OP_POP, $urandom, $urandom);
                end
                case ($urandom_range(0, 2))
                    0: issue(OP_POP, $urandom, $urandom);
                    1: issue(OP_RET, $urandom, $urandom);
                    default: issue(OP_JZ, 32'd4, $urandom);
                endcase
            end
            4:
            begin
                issue(OP_MOV, 32'd1, 32'h7FFF_FFFF);
                issue(OP_MOV, 32'd2, 32'd1);
                make_room();
                issue(OP_ADD, 32'd1, 32'd2);
            end
            5:
            begin
                issue(OP_MOV, 32'd1, 32'h8000_0000);
                issue(OP_MOV, 32'd2, 32'd1);
                make_room();
                issue(OP_SUB, 32'd1, 32'd2);
            end
            6:
            begin
                issue(OP_MOV, 32'd2, 32'd0);
                make_room();
                issue(OP_DIV, 32'd1, 32'd2);
            end
            7:
            begin
                // The one quotient that does not fit: most negative by minus one.
                issue(OP_MOV, 32'd1, 32'h8000_0000);
                issue(OP_MOV, 32'd2, 32'hFFFF_FFFF);
                make_room();
                issue(OP_DIV, 32'd1, 32'd2);
            end
            8:
            begin
                do
                    c = 8'($urandom_range(3, 255));
                while (c inside {OP_PUSH, OP_POP, OP_MOV, OP_CALL, OP_RET, OP_JMP, OP_JZ,
                                 OP_JPOS, OP_JNEG, OP_ADD, OP_SUB, OP_MUL, OP_DIV});
                issue(c, $urandom, $urandom);
            end
            default: issue(OP_JMP, {16'($urandom), 16'hFFFF}, $urandom);
        endcase
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: operand extremes, every operation but halt, print edge counts.
        issue(OP_MOV, 32'd1, 32'h7FFF_FFFF);
        issue(OP_MOV, 32'd2, 32'h8000_0000);
        issue(OP_MOV, 32'd3, 32'hFFFF_FFFF);
        issue(OP_MOV, 32'hFFFF_FFFF, 32'd1);
        issue(OP_MOV, 32'd32, 32'd5);
        issue(OP_DISPLAY, 32'hFFFF_FFFF, 32'd0);
        issue(OP_PRINT, 32'd5, 32'd0);
        issue(OP_PUSH, 32'd1, 32'd0);
        issue(OP_PUSH, 32'd2, 32'd0);
        issue(OP_PUSH, 32'd3, 32'd0);
        issue(OP_PRINT, 32'd0, 32'd0);
        issue(OP_PRINT, 32'hFFFF_FFFF, 32'd0);
        issue(OP_PRINT, 32'd2, 32'd0);
        issue(OP_PRINT, 32'h7FFF_FFFF, 32'd0);
        issue(OP_ADD, 32'd1, 32'd2);
        issue(OP_SUB, 32'd3, 32'd1);
        issue(OP_MUL, 32'd3, 32'd3);
        issue(OP_DIV, 32'd2, 32'd31);
        issue(OP_DIV, 32'd1, 32'd3);
        issue(OP_POP, 32'd4, 32'd0);
        issue(OP_JZ, 32'd100, 32'd0);
        issue(OP_JPOS, 32'hABCD_000A, 32'd0);
        issue(OP_JNEG, 32'd40, 32'd0);
        issue(OP_CALL, 32'h1234_00C8, 32'd0);
        issue(OP_RET, 32'd0, 32'd0);
        issue(OP_JMP, 32'h1234_0050, 32'd0);

        run_random(120, 1'b1);
        write_length(16'd40);
        run_random(100, 1'b0);
        write_length(16'hFFFF);
        run_random(110, 1'b0);

        provoke_stop();
        // Ignored traffic on a stopped block, every field fully random.
        repeat (15)
            issue(8'($urandom), $urandom, $urandom);
        write_length(16'd0);
        issue(8'($urandom), $urandom, $urandom);

        wait_drained();
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** stack_register_vm_executor: PASSED **");
        else
            $display("** stack_register_vm_executor: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/srvm_pkg.sv
sv/srvm_ram.sv
sv/srvm_index_reduce.sv
sv/srvm_divider.sv
sv/stack_register_vm_executor.sv
verif/stack_register_vm_executor_checker.sv
verif/stack_register_vm_executor_tb.sv
